// ===== rtl/slbp_pkg.sv =====
package slbp_pkg;

    // Default sizing
    localparam int COS_DEPTH_DEF  = 256;
    localparam int PHASE_BITS_DEF = 24;

    // Field widths
    localparam int CFG_W    = 7;
    localparam int PWM_W    = 12;
    localparam int RATE_W   = 6;
    localparam int WEIGHT_W = 9;
    localparam int COS_W    = 13;

    // Request codes
    typedef enum logic [1:0] {
        REQ_MODE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_STOP = 2'd2
    } t_req;

    // Configuration register indexes
    typedef enum logic {
        CFG_SMOOTHNESS = 1'b0,
        CFG_MAX_BRIGHT = 1'b1
    } t_cfg_reg;

    // Operating modes with a dedicated color mix
    localparam logic [2:0] MODE_SERVICE  = 3'd0;
    localparam logic [2:0] MODE_CALIB    = 3'd1;
    localparam logic [2:0] MODE_ERROR    = 3'd2;
    localparam logic [2:0] MODE_MANEUVER = 3'd3;
    localparam logic [2:0] MODE_BOOT     = 3'd5;

    // Color weights, Q1.8
    localparam logic [WEIGHT_W-1:0] W_NONE  = 9'd0;
    localparam logic [WEIGHT_W-1:0] W_FULL  = 9'd256;
    localparam logic [WEIGHT_W-1:0] W_HALF  = 9'd128;
    localparam logic [WEIGHT_W-1:0] W_THIRD = 9'd84;

    // Tick rates in Hz
    localparam logic [RATE_W-1:0] RATE_RESET  = 6'd10;
    localparam logic [RATE_W-1:0] RATE_NORMAL = 6'd25;
    localparam logic [RATE_W-1:0] RATE_FAST   = 6'd50;

    // Register reset values and limits
    localparam logic [CFG_W-1:0] SMOOTH_RESET     = 7'd50;
    localparam logic [CFG_W-1:0] MAX_BRIGHT_RESET = 7'd50;
    localparam logic [CFG_W-1:0] SMOOTH_MAX       = 7'd100;
    localparam logic [CFG_W-1:0] SMOOTH_SPAN      = 7'd101;

    // Phase step: (101 - s) * K in Q16 at a 24-bit phase
    localparam logic [29:0] K_STEP         = 30'd874963553;
    localparam int          STEP_FRAC_BITS = 40;
    localparam int          STEP_PROD_W    = 37;

    // Duty arithmetic
    localparam logic [PWM_W-1:0] FULL_DUTY   = 12'd4095;
    localparam logic [COS_W-1:0] Q12_ONE     = 13'd4096;
    localparam logic [40:0]      DUTY_ROUND  = 41'd52428800;
    localparam int               DUTY_SHIFT  = 20;
    localparam logic [19:0]      RECIP_100   = 20'd671089;
    localparam int               RECIP_SHIFT = 26;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Channel sequencing: red, green, blue
    localparam logic [1:0] CH_LAST = 2'd2;

    // Quarter-wave table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Q12 cosine of a Q30 angle from a truncated Taylor series, clamped at zero
    function automatic logic [COS_W-1:0] cos_q12(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        term = ((term * x2) >> 30) / 64'd2;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd240;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        rnd = ($unsigned(sum) + 64'd131072) >> 18;
        return rnd[COS_W-1:0];
    endfunction

endpackage

// ===== rtl/status_led_breathing_pwm.sv =====
// Mode beat: gives no result and leaves the block idle; a new beat can follow in the next cycle.
// Stop beat: result is loaded from the done state, which follows acceptance, once the output register is free.
// Tick beat: step, phase, lookup and three channel passes through one shared 31x20 multiplier,
//   result loaded from the done state; no new beat is taken until the block is idle again,
//   and the done state holds while an earlier result still waits in the output register.
// Synchronous active-low reset: phase 0, weights 0, rate 10 Hz, both registers 50, no result.
module status_led_breathing_pwm
    import slbp_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_req_type,
    input  logic [2:0]        i_op_mode,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PWM_W-1:0]  o_pwm_red,
    output logic [PWM_W-1:0]  o_pwm_green,
    output logic [PWM_W-1:0]  o_pwm_blue,
    output logic [RATE_W-1:0] o_tick_rate_hz
);

    localparam int LOG2_DEPTH = $clog2(COS_TABLE_DEPTH);
    localparam int TAB_IDX_W  = LOG2_DEPTH + 1;
    localparam int STEP_SHIFT = STEP_FRAC_BITS - PHASE_BITS;
    localparam logic [STEP_PROD_W:0] STEP_ROUND = (STEP_PROD_W + 1)'(1) << (STEP_SHIFT - 1);
    localparam int QUOT_W     = PROD_W - RECIP_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_RSTEP,
        S_PHASE,
        S_LOOK,
        S_G,
        S_H,
        S_P,
        S_R,
        S_V,
        S_C,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_out_valid;
    logic [CFG_W-1:0]      r_smooth;
    logic [CFG_W-1:0]      r_max_bright;
    logic [PHASE_BITS-1:0] r_phase;
    logic [WEIGHT_W-1:0]   r_weight [0:2];
    logic [RATE_W-1:0]     r_rate;
    logic [1:0]            r_ch;
    logic [PROD_W-1:0]     r_prod;
    logic [PHASE_BITS-1:0] r_step;
    logic [COS_W-1:0]      r_bright;
    logic [MUL_A_W-1:0]    r_h;
    logic [MUL_B_W-1:0]    r_t;
    logic [PWM_W-1:0]      r_duty [0:2];
    logic [PWM_W-1:0]      r_pwm_red;
    logic [PWM_W-1:0]      r_pwm_green;
    logic [PWM_W-1:0]      r_pwm_blue;
    logic [RATE_W-1:0]     r_out_rate;

    logic [PHASE_BITS-1:0] n_step;
    logic [COS_W-1:0]      n_bright;
    logic [MUL_B_W-1:0]    n_t;
    logic [PWM_W-1:0]      n_duty;

    logic [COS_W-1:0]      w_cos_tab [0:COS_TABLE_DEPTH];
    logic [CFG_W-1:0]      w_smooth_eff;
    logic [CFG_W-1:0]      w_factor;
    logic [MUL_A_W-1:0]    w_mul_a;
    logic [MUL_B_W-1:0]    w_mul_b;
    logic [PROD_W-1:0]     w_mul;
    logic [STEP_PROD_W:0]  w_step_sum;
    logic [1:0]            w_quad;
    logic [LOG2_DEPTH-1:0] w_frac;
    logic [TAB_IDX_W-1:0]  w_tab_idx;
    logic [COS_W-1:0]      w_mag;
    logic [COS_W:0]        w_bright_sum;
    logic [40:0]           w_duty_sum;
    logic [QUOT_W-1:0]     w_quot;
    logic                  w_in_fire;

    // Build the quarter-wave cosine table at elaboration
    for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos
        localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
        assign w_cos_tab[k] = cos_q12(ANGLE);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;

    // Clamp smoothness and form the step factor
    assign w_smooth_eff = (r_smooth > SMOOTH_MAX) ? SMOOTH_MAX : r_smooth;
    assign w_factor     = SMOOTH_SPAN - w_smooth_eff;

    // Select operands of the shared multiplier
    always_comb begin
        unique case (r_state)
            S_STEP: begin
                w_mul_a = MUL_A_W'(K_STEP);
                w_mul_b = MUL_B_W'(w_factor);
            end
            S_G: begin
                w_mul_a = MUL_A_W'(r_bright);
                w_mul_b = MUL_B_W'(r_max_bright);
            end
            S_H: begin
                w_mul_a = MUL_A_W'(r_prod[MUL_B_W-1:0]);
                w_mul_b = MUL_B_W'(FULL_DUTY);
            end
            S_P: begin
                w_mul_a = r_h;
                w_mul_b = MUL_B_W'(r_weight[r_ch]);
            end
            S_V: begin
                w_mul_a = MUL_A_W'(r_t);
                w_mul_b = RECIP_100;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // Round the phase step
    assign w_step_sum = (STEP_PROD_W + 1)'(r_prod[STEP_PROD_W-1:0]) + STEP_ROUND;
    assign n_step     = PHASE_BITS'(w_step_sum >> STEP_SHIFT);

    // Fold the phase onto the quarter-wave table
    assign w_quad    = r_phase[PHASE_BITS-1 -: 2];
    assign w_frac    = r_phase[PHASE_BITS-3 -: LOG2_DEPTH];
    assign w_tab_idx = w_quad[0] ? (TAB_IDX_W'(COS_TABLE_DEPTH) - TAB_IDX_W'(w_frac))
                                 : TAB_IDX_W'(w_frac);
    assign w_mag     = w_cos_tab[w_tab_idx];

    // Brightness (1 + cos) / 2 in Q1.12, cosine negative in the middle quadrants
    assign w_bright_sum = (w_quad[1] ^ w_quad[0]) ? ((COS_W + 1)'(Q12_ONE) - (COS_W + 1)'(w_mag))
                                                  : ((COS_W + 1)'(Q12_ONE) + (COS_W + 1)'(w_mag));
    assign n_bright     = w_bright_sum[COS_W:1];

    // Round the duty product before the divide by 100
    assign w_duty_sum = 41'(r_prod[39:0]) + DUTY_ROUND;
    assign n_t        = MUL_B_W'(w_duty_sum >> DUTY_SHIFT);

    // Invert and clamp the duty
    assign w_quot = r_prod[PROD_W-1:RECIP_SHIFT];
    assign n_duty = (w_quot >= QUOT_W'(FULL_DUTY)) ? '0 : (FULL_DUTY - w_quot[PWM_W-1:0]);

    // Sequencer, state and result registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_smooth     <= SMOOTH_RESET;
            r_max_bright <= MAX_BRIGHT_RESET;
            r_phase      <= '0;
            r_weight[0]  <= W_NONE;
            r_weight[1]  <= W_NONE;
            r_weight[2]  <= W_NONE;
            r_rate       <= RATE_RESET;
            r_ch         <= '0;
        end else begin
            // take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SMOOTHNESS: r_smooth     <= i_cfg_wdata;
                    CFG_MAX_BRIGHT: r_max_bright <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // drop a result once it is taken, unless the done state reloads it
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        unique case (i_req_type)
                            REQ_MODE: begin
                                r_rate <= (i_op_mode == MODE_BOOT) ? RATE_FAST : RATE_NORMAL;
                                unique case (i_op_mode)
                                    MODE_CALIB: begin
                                        r_weight[0] <= W_NONE;
                                        r_weight[1] <= W_NONE;
                                        r_weight[2] <= W_FULL;
                                    end
                                    MODE_SERVICE: begin
                                        r_weight[0] <= W_NONE;
                                        r_weight[1] <= W_FULL;
                                        r_weight[2] <= W_NONE;
                                    end
                                    MODE_ERROR: begin
                                        r_weight[0] <= W_FULL;
                                        r_weight[1] <= W_NONE;
                                        r_weight[2] <= W_NONE;
                                    end
                                    MODE_MANEUVER: begin
                                        r_weight[0] <= W_HALF;
                                        r_weight[1] <= W_HALF;
                                        r_weight[2] <= W_NONE;
                                    end
                                    MODE_BOOT: begin
                                        r_weight[0] <= W_HALF;
                                        r_weight[1] <= W_NONE;
                                        r_weight[2] <= W_HALF;
                                    end
                                    default: begin
                                        r_weight[0] <= W_THIRD;
                                        r_weight[1] <= W_THIRD;
                                        r_weight[2] <= W_THIRD;
                                    end
                                endcase
                            end
                            REQ_TICK: begin
                                r_state <= S_STEP;
                            end
                            REQ_STOP: begin
                                r_duty[0] <= FULL_DUTY;
                                r_duty[1] <= FULL_DUTY;
                                r_duty[2] <= FULL_DUTY;
                                r_state   <= S_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_STEP: begin
                    r_state <= S_RSTEP;
                end
                S_RSTEP: begin
                    r_step  <= n_step;
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    r_phase <= r_phase + r_step;
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_bright <= n_bright;
                    r_state  <= S_G;
                end
                S_G: begin
                    r_state <= S_H;
                end
                S_H: begin
                    r_h     <= w_mul[MUL_A_W-1:0];
                    r_ch    <= '0;
                    r_state <= S_P;
                end
                S_P: begin
                    r_state <= S_R;
                end
                S_R: begin
                    r_t     <= n_t;
                    r_state <= S_V;
                end
                S_V: begin
                    r_state <= S_C;
                end
                S_C: begin
                    r_duty[r_ch] <= n_duty;
                    if (r_ch == CH_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_P;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_pwm_red   <= r_duty[0];
                        r_pwm_green <= r_duty[1];
                        r_pwm_blue  <= r_duty[2];
                        r_out_rate  <= r_rate;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pwm_red      = r_pwm_red;
    assign o_pwm_green    = r_pwm_green;
    assign o_pwm_blue     = r_pwm_blue;
    assign o_tick_rate_hz = r_out_rate;

    // A mode or tick beat never produces a result in the next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_req_type != REQ_STOP && !r_out_valid) |=> !r_out_valid)
        else $error("result raised right after a non-stop beat");

    // A result only appears out of the done state
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

    // Channel counter stays within red, green, blue
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P || r_state == S_C) |-> (r_ch <= CH_LAST))
        else $error("channel counter out of range");

    // Brightness stays within Q1.12 unity
    a_bright_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_G) |-> (r_bright <= Q12_ONE))
        else $error("brightness above unity");

endmodule
